@@ rtl/alt_bit_receiver_with_handshake_macros.svh @@
// Assertion macros for the alternating-bit receiver.
// Included by the top level; no other dependencies.
`ifndef ALT_BIT_RECEIVER_WITH_HANDSHAKE_MACROS_SVH
`define ALT_BIT_RECEIVER_WITH_HANDSHAKE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled in reset
`define ABR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");
// Next-cycle implication, disabled in reset
`define ABR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");
`else
`define ABR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ABR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/abr_pkg.sv @@
// Package for the alternating-bit receiver: field widths, constants, state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package abr_pkg;

  localparam int SEQ_W   = 8;
  localparam int LOSS_W  = 7;
  localparam int STATE_W = 3;

  // Sequence field sent in every reply that is not a SYNACK
  localparam logic [SEQ_W-1:0]  PLAIN_SEQ  = 8'd42;
  // Loss percent after reset
  localparam logic [LOSS_W-1:0] LOSS_RESET = 7'd40;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_SYNRCVD = 3'd1,
    ST_ESTAB   = 3'd2,
    ST_FINWAIT = 3'd3,
    ST_CLOSED  = 3'd4
  } abr_state_t;

endpackage

`default_nettype wire

@@ rtl/abr_if.sv @@
// Handshake channels of the alternating-bit receiver: header in, reply out, config.
// Depends on abr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface abr_in_if;
  import abr_pkg::*;
  logic               valid;
  logic               ready;
  logic [SEQ_W-1:0]   seq_field;
  logic               syn_flag;
  logic               ack_flag;
  logic               fin_flag;
  modport source (output valid, seq_field, syn_flag, ack_flag, fin_flag, input ready);
  modport sink   (input valid, seq_field, syn_flag, ack_flag, fin_flag, output ready);
endinterface

interface abr_out_if;
  import abr_pkg::*;
  logic               valid;
  logic               ready;
  logic               send_reply;
  logic               reply_syn;
  logic               reply_ack;
  logic               reply_fin;
  logic               reply_ack_bit;
  logic [SEQ_W-1:0]   reply_seq;
  logic               deliver_payload;
  logic [STATE_W-1:0] link_state;
  modport source (output valid, send_reply, reply_syn, reply_ack, reply_fin, reply_ack_bit,
                  reply_seq, deliver_payload, link_state, input ready);
  modport sink   (input valid, send_reply, reply_syn, reply_ack, reply_fin, reply_ack_bit,
                  reply_seq, deliver_payload, link_state, output ready);
endinterface

interface abr_cfg_if;
  import abr_pkg::*;
  logic               valid;
  logic               ready;
  logic [LOSS_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/alt_bit_receiver_with_handshake.sv @@
// Alternating-bit receiver endpoint: connection state, sequence check, reply build.
// Depends on abr_pkg, the channel interfaces in abr_if.sv and the assertion macros.
//
//  channel   | dir | payload                                         | beat taken when
//  in_beat   | in  | seq_field, syn/ack/fin flags                    | valid && ready
//  out_beat  | out | reply flags, ack bit, seq, deliver, link_state  | valid && ready
//  cfg_wr    | in  | local loss percent (7 bits)                     | valid && ready
//
// One header beat per cycle; each beat yields one reply beat on the next cycle.
// The state update and reply logic sit in one pass in front of the output register.
// in_beat stalls only while the output register holds a beat out_beat has not taken.
// cfg_wr is always ready; a write reloads the negotiated loss.
// rst_n (synchronous) returns to idle, expected bit 0, loss 40; output empty.
`timescale 1ns / 1ps
`default_nettype none

`include "alt_bit_receiver_with_handshake_macros.svh"

module alt_bit_receiver_with_handshake (
  input  wire logic  clk,
  input  wire logic  rst_n,
  abr_in_if.sink     in_beat,
  abr_out_if.source  out_beat,
  abr_cfg_if.sink    cfg_wr
);
  import abr_pkg::*;

  abr_state_t          state_r, state_nxt;
  logic                exp_bit_r, exp_bit_nxt;
  logic [LOSS_W-1:0]   loss_r, loss_nxt;

  logic                out_valid_r;
  logic                send_r, rsyn_r, rack_r, rfin_r, rbit_r, deliver_r;
  logic [SEQ_W-1:0]    rseq_r;
  abr_state_t          link_r;

  logic                send_nxt, rsyn_nxt, rack_nxt, rfin_nxt, rbit_nxt, deliver_nxt;
  logic [SEQ_W-1:0]    rseq_nxt;

  logic                in_acc;
  logic                in_seq_match;

  // Take a header whenever the output register is free or being drained
  assign in_beat.ready = !out_valid_r || out_beat.ready;
  assign in_acc        = in_beat.valid && in_beat.ready;
  assign cfg_wr.ready  = 1'b1;

  assign in_seq_match = (in_beat.seq_field == {{(SEQ_W-1){1'b0}}, exp_bit_r});

  // Next state and reply for the header on the input
  always_comb begin
    state_nxt   = state_r;
    exp_bit_nxt = exp_bit_r;
    loss_nxt    = loss_r;
    send_nxt    = 1'b0;
    rsyn_nxt    = 1'b0;
    rack_nxt    = 1'b0;
    rfin_nxt    = 1'b0;
    rbit_nxt    = 1'b0;
    rseq_nxt    = '0;
    deliver_nxt = 1'b0;
    case (state_r)
      ST_ESTAB: begin
        send_nxt = 1'b1;
        rack_nxt = 1'b1;
        rseq_nxt = PLAIN_SEQ;
        if (in_seq_match) begin
          // in-sequence data wins over any flags
          deliver_nxt = 1'b1;
          exp_bit_nxt = ~exp_bit_r;
          rbit_nxt    = ~exp_bit_r;
        end else if (in_beat.fin_flag && !in_beat.ack_flag && !in_beat.syn_flag) begin
          state_nxt = ST_FINWAIT;
          rfin_nxt  = 1'b1;
          rbit_nxt  = exp_bit_r;
        end else begin
          // duplicate: acknowledge again
          rbit_nxt = exp_bit_r;
        end
      end
      ST_FINWAIT: begin
        if (in_beat.ack_flag && !in_beat.syn_flag && !in_beat.fin_flag) begin
          state_nxt = ST_CLOSED;
        end else begin
          send_nxt = 1'b1;
          rack_nxt = 1'b1;
          rfin_nxt = 1'b1;
          rbit_nxt = exp_bit_r;
          rseq_nxt = PLAIN_SEQ;
        end
      end
      ST_IDLE: begin
        if (in_beat.syn_flag) begin
          // lower the loss to the peer's offer if it is smaller
          if (in_beat.seq_field < {1'b0, loss_r}) begin
            loss_nxt = in_beat.seq_field[LOSS_W-1:0];
          end
          state_nxt = ST_SYNRCVD;
          send_nxt  = 1'b1;
          rsyn_nxt  = 1'b1;
          rack_nxt  = 1'b1;
          rbit_nxt  = exp_bit_r;
          rseq_nxt  = {1'b0, loss_nxt};
        end
      end
      ST_SYNRCVD: begin
        if (in_beat.ack_flag) begin
          state_nxt = ST_ESTAB;
        end
      end
      default: begin
        // closed or unused code: ignore the header
      end
    endcase
  end

  // Advance connection state on each accepted header; config reloads the loss
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      exp_bit_r <= 1'b0;
      loss_r    <= LOSS_RESET;
    end else begin
      if (in_acc) begin
        state_r   <= state_nxt;
        exp_bit_r <= exp_bit_nxt;
      end
      if (cfg_wr.valid && cfg_wr.ready) begin
        loss_r <= cfg_wr.data;
      end else if (in_acc) begin
        loss_r <= loss_nxt;
      end
    end
  end

  // Output valid: set on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the reply payload until the next accepted header
  always_ff @(posedge clk) begin
    if (in_acc) begin
      send_r    <= send_nxt;
      rsyn_r    <= rsyn_nxt;
      rack_r    <= rack_nxt;
      rfin_r    <= rfin_nxt;
      rbit_r    <= rbit_nxt;
      rseq_r    <= rseq_nxt;
      deliver_r <= deliver_nxt;
      link_r    <= state_nxt;
    end
  end

  assign out_beat.valid           = out_valid_r;
  assign out_beat.send_reply      = send_r;
  assign out_beat.reply_syn       = rsyn_r;
  assign out_beat.reply_ack       = rack_r;
  assign out_beat.reply_fin       = rfin_r;
  assign out_beat.reply_ack_bit   = rbit_r;
  assign out_beat.reply_seq       = rseq_r;
  assign out_beat.deliver_payload = deliver_r;
  assign out_beat.link_state      = link_r;

  // Every accepted header leaves a beat in the output register
  `ABR_ASSERT_NXT(a_accept_fills_out, clk, rst_n, in_acc, out_valid_r)
  // Delivery only ever happens in the established state, with an ACK reply
  `ABR_ASSERT_IMP(a_deliver_estab, clk, rst_n, out_valid_r && deliver_r,
                  send_r && rack_r && !rsyn_r && link_r == ST_ESTAB)
  // A sent reply always carries the ACK flag
  `ABR_ASSERT_IMP(a_reply_has_ack, clk, rst_n, out_valid_r && send_r, rack_r)
  // Closed is final
  `ABR_ASSERT_NXT(a_closed_stays, clk, rst_n, state_r == ST_CLOSED, state_r == ST_CLOSED)

endmodule

`default_nettype wire
